>>> rtl/core/mhs_pkg.sv
// Shared constants, types and the arctangent table of the heading selector.
package mhs_pkg;

    // Pipeline depth and output angle format
    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 7;

    // Angle accumulator holds degrees times 2^ACC_FRAC
    localparam int ACC_FRAC  = 20;
    localparam int TABLE_LEN = 24;
    localparam int NUM_ITER  = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    // Vector width: 16-bit input scaled by 2^16, grown by sqrt(2) and the CORDIC gain
    localparam int XY_W = 36;
    // Signed accumulator width and folded (unsigned) accumulator width
    localparam int Z_W  = 31;
    localparam int ZF_W = 29;

    // Rounding shift from accumulator to output format
    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    // Width of the rounded angle before the 360-degree wrap
    localparam int HW = ZF_W + 1 - SH;

    localparam int HEAD_W = 16;

    localparam logic signed [Z_W-1:0] FULL_TURN_ACC = Z_W'(360 * (1 << ACC_FRAC));
    localparam logic signed [Z_W-1:0] HALF_TURN_ACC = Z_W'(180 * (1 << ACC_FRAC));
    localparam logic [HW-1:0]         FULL_TURN_OUT = HW'(360 * (1 << ANGLE_FRAC_BITS));
    localparam logic [HEAD_W-1:0]     HEADING_MAX   =
        HEAD_W'(360 * (1 << ANGLE_FRAC_BITS) - 1);

    // Heading source codes
    typedef enum logic [1:0] {
        SRC_COMPASS = 2'd0,
        SRC_GPS     = 2'd1,
        SRC_NONE    = 2'd2
    } src_t;

    // atan(2^-i) in degrees times 2^ACC_FRAC, rounded to nearest
    function automatic logic signed [Z_W-1:0] atan_deg(input int idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            0:       val = Z_W'(47185920);
            1:       val = Z_W'(27855475);
            2:       val = Z_W'(14718068);
            3:       val = Z_W'(7471121);
            4:       val = Z_W'(3750058);
            5:       val = Z_W'(1876857);
            6:       val = Z_W'(938658);
            7:       val = Z_W'(469357);
            8:       val = Z_W'(234682);
            9:       val = Z_W'(117342);
            10:      val = Z_W'(58671);
            11:      val = Z_W'(29335);
            12:      val = Z_W'(14668);
            13:      val = Z_W'(7334);
            14:      val = Z_W'(3667);
            15:      val = Z_W'(1833);
            16:      val = Z_W'(917);
            17:      val = Z_W'(458);
            18:      val = Z_W'(229);
            19:      val = Z_W'(115);
            20:      val = Z_W'(57);
            21:      val = Z_W'(29);
            22:      val = Z_W'(14);
            23:      val = Z_W'(7);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

>>> rtl/core/magnetometer_heading_select_top.sv
// Heading selector: pipelined CORDIC atan2 of the magnetometer vector, GPS course fallback.
// Each accepted beat passes the input, iteration, fold and output registers in that order;
// its result then appears on the ports with done high.
// Throughput: one beat per clock cycle; busy stays low, set by one CORDIC iteration per stage.
// Stages: input conditioning, one register per CORDIC iteration, angle fold, round and select.
// Reset: rst_n asynchronous active low clears all valid bits and done; payload is not reset.
// The receiver cannot stall; every result appears for exactly one cycle.
module magnetometer_heading_select_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        compass_valid,
    input  logic [15:0] raw_x,
    input  logic [15:0] raw_y,
    input  logic        gps_fix,
    input  logic [15:0] gps_course,
    output logic        done,
    output logic [15:0] heading,
    output logic [1:0]  heading_source
);
    import mhs_pkg::*;

    localparam int LATENCY = NUM_ITER + 3;

    // Stage 0 next values
    logic                    use_cordic_next;
    src_t                    src_next;
    logic [HEAD_W-1:0]       alt_next;
    logic signed [XY_W-1:0]  x_ext;
    logic signed [XY_W-1:0]  y_ext;
    logic signed [XY_W-1:0]  x0_next;
    logic signed [XY_W-1:0]  y0_next;
    logic signed [Z_W-1:0]   z0_next;

    // CORDIC stage registers: index k feeds iteration k
    logic                    vld_reg        [0:NUM_ITER];
    logic                    use_cordic_reg [0:NUM_ITER];
    src_t                    src_reg        [0:NUM_ITER];
    logic [HEAD_W-1:0]       alt_reg        [0:NUM_ITER];
    logic signed [XY_W-1:0]  x_reg          [0:NUM_ITER];
    logic signed [XY_W-1:0]  y_reg          [0:NUM_ITER];
    logic signed [Z_W-1:0]   z_reg          [0:NUM_ITER];

    logic signed [XY_W-1:0]  x_next [0:NUM_ITER-1];
    logic signed [XY_W-1:0]  y_next [0:NUM_ITER-1];
    logic signed [Z_W-1:0]   z_next [0:NUM_ITER-1];

    // Fold stage
    logic                    f_vld_reg;
    logic                    f_use_cordic_reg;
    src_t                    f_src_reg;
    logic [HEAD_W-1:0]       f_alt_reg;
    logic [ZF_W-1:0]         f_z_reg;
    logic [ZF_W-1:0]         f_z_next;
    logic signed [Z_W-1:0]   z_fold;

    // Output stage
    logic                    done_reg;
    logic [HEAD_W-1:0]       heading_reg;
    src_t                    source_reg;
    logic [HEAD_W-1:0]       heading_next;
    logic [ZF_W:0]           round_sum;
    logic [HW-1:0]           round_h;

    logic accept;

    // The pipeline never stalls
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Condition the input beat: scale, turn left half plane by 180 degrees, pick source
    always_comb
    begin
        x_ext = {{(XY_W-32){raw_x[15]}}, raw_x, 16'h0000};
        y_ext = {{(XY_W-32){raw_y[15]}}, raw_y, 16'h0000};
        if (raw_x[15])
        begin
            x0_next = -x_ext;
            y0_next = -y_ext;
            z0_next = HALF_TURN_ACC;
        end
        else
        begin
            x0_next = x_ext;
            y0_next = y_ext;
            z0_next = '0;
        end

        use_cordic_next = 1'b0;
        alt_next        = '0;
        if (compass_valid)
        begin
            src_next        = SRC_COMPASS;
            use_cordic_next = (raw_x != 16'h0000) || (raw_y != 16'h0000);
        end
        else if (gps_fix)
        begin
            src_next = SRC_GPS;
            alt_next = (gps_course > HEADING_MAX) ? HEADING_MAX : gps_course;
        end
        else
        begin
            src_next = SRC_NONE;
        end
    end

    // One vectoring iteration per stage: drive y toward zero
    for (genvar i = 0; i < NUM_ITER; i++)
    begin : g_iter
        always_comb
        begin
            if (y_reg[i] > 0)
            begin
                x_next[i] = x_reg[i] + (y_reg[i] >>> i);
                y_next[i] = y_reg[i] - (x_reg[i] >>> i);
                z_next[i] = z_reg[i] + atan_deg(i);
            end
            else
            begin
                x_next[i] = x_reg[i] - (y_reg[i] >>> i);
                y_next[i] = y_reg[i] + (x_reg[i] >>> i);
                z_next[i] = z_reg[i] - atan_deg(i);
            end
        end
    end

    // Fold the angle into [0, 360)
    always_comb
    begin
        z_fold = z_reg[NUM_ITER];
        if (z_fold < 0)
        begin
            z_fold = z_fold + FULL_TURN_ACC;
        end
        else if (z_fold >= FULL_TURN_ACC)
        begin
            z_fold = z_fold - FULL_TURN_ACC;
        end
        if (z_fold < 0)
        begin
            z_fold = '0;
        end
        f_z_next = z_fold[ZF_W-1:0];
    end

    // Round to the output format, wrap 360 to 0, select the source
    always_comb
    begin
        round_sum = {1'b0, f_z_reg} + (ZF_W+1)'(1 << (SH - 1));
        round_h   = round_sum[ZF_W:SH];
        if (round_h >= FULL_TURN_OUT)
        begin
            round_h = round_h - FULL_TURN_OUT;
        end
        if (f_use_cordic_reg)
        begin
            heading_next = round_h[HEAD_W-1:0];
        end
        else
        begin
            heading_next = f_alt_reg;
        end
    end

    // Advance valid bits and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= NUM_ITER; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            f_vld_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 0; k < NUM_ITER; k++)
            begin
                vld_reg[k+1] <= vld_reg[k];
            end
            f_vld_reg <= vld_reg[NUM_ITER];
            done_reg  <= f_vld_reg;
        end
    end

    // Advance the payload of every stage
    always_ff @(posedge clk)
    begin
        use_cordic_reg[0] <= use_cordic_next;
        src_reg[0]        <= src_next;
        alt_reg[0]        <= alt_next;
        x_reg[0]          <= x0_next;
        y_reg[0]          <= y0_next;
        z_reg[0]          <= z0_next;
        for (int k = 0; k < NUM_ITER; k++)
        begin
            use_cordic_reg[k+1] <= use_cordic_reg[k];
            src_reg[k+1]        <= src_reg[k];
            alt_reg[k+1]        <= alt_reg[k];
            x_reg[k+1]          <= x_next[k];
            y_reg[k+1]          <= y_next[k];
            z_reg[k+1]          <= z_next[k];
        end
        f_use_cordic_reg <= use_cordic_reg[NUM_ITER];
        f_src_reg        <= src_reg[NUM_ITER];
        f_alt_reg        <= alt_reg[NUM_ITER];
        f_z_reg          <= f_z_next;
        heading_reg      <= heading_next;
        source_reg       <= f_src_reg;
    end

    assign done           = done_reg;
    assign heading        = heading_reg;
    assign heading_source = source_reg;

`ifndef NO_ASSERTIONS
    // Every accepted beat yields a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("accepted beat produced no result at the expected cycle");

    // Heading stays below a full turn
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (heading <= HEADING_MAX))
        else $error("heading out of range");

    // No-update results carry a zero heading
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (heading_source == SRC_NONE)) |-> (heading == '0))
        else $error("no-update result with nonzero heading");

    // Source code is one of the defined values
    a_src_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ((heading_source == SRC_COMPASS) || (heading_source == SRC_GPS)
                  || (heading_source == SRC_NONE)))
        else $error("undefined heading source");
`endif

endmodule
